[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[sv/dwas_pkg.sv]
// ----------------------------------------------------------------------------
// DWARF attribute skipper package
// Word types, phase encoding, status codes and form codes of the skipper.
// ----------------------------------------------------------------------------
package dwas_pkg;

   localparam int BYTE_W    = 8;
   localparam int SIZE_W    = 4;
   localparam int COUNT_W   = 32;
   localparam int STATUS_W  = 3;
   localparam int REMAIN_W  = 64;
   localparam int SHIFT_W   = 7;
   localparam int LENLEFT_W = 3;
   localparam int PLANCNT_W = 5;
   localparam int CSR_IDX_W = 1;

   localparam logic [SHIFT_W-1:0] LEB_SHIFT_MAX = 7'd64;

   localparam logic OP_FORM = 1'b0;
   localparam logic OP_DATA = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_SIZE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDRESS_SIZE = 1'b1;

   localparam logic [SIZE_W-1:0] OFFSET_SIZE_RESET  = 4'd4;
   localparam logic [SIZE_W-1:0] ADDRESS_SIZE_RESET = 4'd8;

   localparam logic [STATUS_W-1:0] ST_MORE        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DONE        = 3'd1;
   localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_RESERVED    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_UNEXPECTED  = 3'd4;

   localparam logic [BYTE_W-1:0] FORM_ADDR           = 8'h01;
   localparam logic [BYTE_W-1:0] FORM_BLOCK2         = 8'h03;
   localparam logic [BYTE_W-1:0] FORM_BLOCK4         = 8'h04;
   localparam logic [BYTE_W-1:0] FORM_DATA2          = 8'h05;
   localparam logic [BYTE_W-1:0] FORM_DATA4          = 8'h06;
   localparam logic [BYTE_W-1:0] FORM_DATA8          = 8'h07;
   localparam logic [BYTE_W-1:0] FORM_STRING         = 8'h08;
   localparam logic [BYTE_W-1:0] FORM_BLOCK          = 8'h09;
   localparam logic [BYTE_W-1:0] FORM_BLOCK1         = 8'h0A;
   localparam logic [BYTE_W-1:0] FORM_DATA1          = 8'h0B;
   localparam logic [BYTE_W-1:0] FORM_FLAG           = 8'h0C;
   localparam logic [BYTE_W-1:0] FORM_SDATA          = 8'h0D;
   localparam logic [BYTE_W-1:0] FORM_STRP           = 8'h0E;
   localparam logic [BYTE_W-1:0] FORM_UDATA          = 8'h0F;
   localparam logic [BYTE_W-1:0] FORM_REF_ADDR       = 8'h10;
   localparam logic [BYTE_W-1:0] FORM_REF1           = 8'h11;
   localparam logic [BYTE_W-1:0] FORM_REF2           = 8'h12;
   localparam logic [BYTE_W-1:0] FORM_REF4           = 8'h13;
   localparam logic [BYTE_W-1:0] FORM_REF8           = 8'h14;
   localparam logic [BYTE_W-1:0] FORM_REF_UDATA      = 8'h15;
   localparam logic [BYTE_W-1:0] FORM_INDIRECT       = 8'h16;
   localparam logic [BYTE_W-1:0] FORM_SEC_OFFSET     = 8'h17;
   localparam logic [BYTE_W-1:0] FORM_EXPRLOC        = 8'h18;
   localparam logic [BYTE_W-1:0] FORM_FLAG_PRESENT   = 8'h19;
   localparam logic [BYTE_W-1:0] FORM_STRX           = 8'h1A;
   localparam logic [BYTE_W-1:0] FORM_ADDRX          = 8'h1B;
   localparam logic [BYTE_W-1:0] FORM_REF_SUP4       = 8'h1C;
   localparam logic [BYTE_W-1:0] FORM_STRP_SUP       = 8'h1D;
   localparam logic [BYTE_W-1:0] FORM_DATA16         = 8'h1E;
   localparam logic [BYTE_W-1:0] FORM_LINE_STRP      = 8'h1F;
   localparam logic [BYTE_W-1:0] FORM_REF_SIG8       = 8'h20;
   localparam logic [BYTE_W-1:0] FORM_IMPLICIT_CONST = 8'h21;
   localparam logic [BYTE_W-1:0] FORM_LOCLISTX       = 8'h22;
   localparam logic [BYTE_W-1:0] FORM_RNGLISTX       = 8'h23;
   localparam logic [BYTE_W-1:0] FORM_REF_SUP8       = 8'h24;
   localparam logic [BYTE_W-1:0] FORM_STRX1          = 8'h25;
   localparam logic [BYTE_W-1:0] FORM_STRX2          = 8'h26;
   localparam logic [BYTE_W-1:0] FORM_STRX3          = 8'h27;
   localparam logic [BYTE_W-1:0] FORM_STRX4          = 8'h28;
   localparam logic [BYTE_W-1:0] FORM_ADDRX1         = 8'h29;
   localparam logic [BYTE_W-1:0] FORM_ADDRX2         = 8'h2A;
   localparam logic [BYTE_W-1:0] FORM_ADDRX3         = 8'h2B;
   localparam logic [BYTE_W-1:0] FORM_ADDRX4         = 8'h2C;

   typedef enum logic [7:0] {
      PH_IDLE     = 8'b0000_0001,
      PH_FIXED    = 8'b0000_0010,
      PH_LENFIX   = 8'b0000_0100,
      PH_LENLEB   = 8'b0000_1000,
      PH_BLOCK    = 8'b0001_0000,
      PH_STRING   = 8'b0010_0000,
      PH_LEB      = 8'b0100_0000,
      PH_INDIRECT = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic              opcode;
      logic [BYTE_W-1:0] form_code;
      logic [BYTE_W-1:0] data_byte;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  bytes_consumed;
      logic [BYTE_W-1:0]   resolved_form;
   } rsp_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      phase_type            phase;
      logic [PLANCNT_W-1:0] count;
   } form_plan_type;

endpackage

[sv/dwarf_attribute_skipper_core.sv]
// ----------------------------------------------------------------------------
// DWARF attribute skipper core
// Tracks DWARF 5 attribute values through a byte stream and reports where
// each one ends.
// ----------------------------------------------------------------------------
// Each accepted word yields one response word, registered in the output
// register, or in the skid register while the output stalls. The phase,
// length and count registers are updated once per word, which sets the rate
// at one word per clock while req_stall is low. Responses pass through an
// output register backed by a one-word skid register, so the request side
// keeps flowing for one more word after the response side stalls.
`include "assert_macros.svh"

module dwarf_attribute_skipper_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  dwas_pkg::req_word_type            req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output dwas_pkg::rsp_word_type            rsp_word,
   input  logic                              csr_wen,
   input  logic [dwas_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dwas_pkg::SIZE_W-1:0]       csr_wdata
);

   import dwas_pkg::*;

   logic [SIZE_W-1:0]    offset_size_ff;
   logic [SIZE_W-1:0]    address_size_ff;

   phase_type            phase_ff, phase_in;
   logic [REMAIN_W-1:0]  remain_ff, remain_in;
   logic [REMAIN_W-1:0]  length_acc_ff, length_acc_in;
   logic [SHIFT_W-1:0]   shift_ff, shift_in;
   logic [LENLEFT_W-1:0] len_left_ff, len_left_in;
   logic [COUNT_W-1:0]   consumed_ff, consumed_in;
   logic [BYTE_W-1:0]    form_ff, form_in;

   logic                 rsp_valid_ff;
   logic                 skid_valid_ff;
   rsp_word_type         rsp_word_ff;
   rsp_word_type         skid_word_ff;

   logic                 item_take;
   logic                 rsp_take;
   logic [STATUS_W-1:0]  status_c;
   rsp_word_type         result_c;

   logic [REMAIN_W-1:0]  remain_dec;
   logic [REMAIN_W-1:0]  lenfix_acc;
   logic [REMAIN_W-1:0]  leb_acc;
   logic [SHIFT_W-1:0]   leb_shift_sum;
   logic [SHIFT_W-1:0]   leb_shift;
   logic [LENLEFT_W-1:0] len_left_dec;
   logic [COUNT_W-1:0]   consumed_inc;

   logic                 do_begin;
   logic [BYTE_W-1:0]    begin_form;
   logic                 begin_big;
   form_plan_type        plan;

   function automatic form_plan_type plan_form(
      input logic [BYTE_W-1:0] f,
      input logic [SIZE_W-1:0] osz,
      input logic [SIZE_W-1:0] asz
   );
      form_plan_type p;
      p.status = ST_MORE;
      p.phase  = PH_IDLE;
      p.count  = '0;
      case (f)
         FORM_STRP, FORM_SEC_OFFSET, FORM_LINE_STRP, FORM_REF_ADDR: begin
            p.phase = PH_FIXED;
            p.count = {1'b0, osz};
         end
         FORM_ADDR: begin
            p.phase = PH_FIXED;
            p.count = {1'b0, asz};
         end
         FORM_DATA1, FORM_FLAG, FORM_REF1, FORM_STRX1, FORM_ADDRX1: begin
            p.phase = PH_FIXED;
            p.count = 5'd1;
         end
         FORM_DATA2, FORM_REF2, FORM_STRX2, FORM_ADDRX2: begin
            p.phase = PH_FIXED;
            p.count = 5'd2;
         end
         FORM_STRX3, FORM_ADDRX3: begin
            p.phase = PH_FIXED;
            p.count = 5'd3;
         end
         FORM_DATA4, FORM_REF4, FORM_STRX4, FORM_ADDRX4: begin
            p.phase = PH_FIXED;
            p.count = 5'd4;
         end
         FORM_DATA8, FORM_REF8, FORM_REF_SIG8: begin
            p.phase = PH_FIXED;
            p.count = 5'd8;
         end
         FORM_DATA16: begin
            p.phase = PH_FIXED;
            p.count = 5'd16;
         end
         FORM_BLOCK1: begin
            p.phase = PH_LENFIX;
            p.count = 5'd1;
         end
         FORM_BLOCK2: begin
            p.phase = PH_LENFIX;
            p.count = 5'd2;
         end
         FORM_BLOCK4: begin
            p.phase = PH_LENFIX;
            p.count = 5'd4;
         end
         FORM_BLOCK, FORM_EXPRLOC: begin
            p.phase = PH_LENLEB;
         end
         FORM_STRING: begin
            p.phase = PH_STRING;
         end
         FORM_SDATA, FORM_UDATA, FORM_REF_UDATA, FORM_STRX, FORM_ADDRX,
         FORM_LOCLISTX, FORM_RNGLISTX: begin
            p.phase = PH_LEB;
         end
         FORM_INDIRECT: begin
            p.phase = PH_INDIRECT;
         end
         FORM_FLAG_PRESENT, FORM_IMPLICIT_CONST: begin
            p.status = ST_DONE;
         end
         FORM_REF_SUP4, FORM_STRP_SUP, FORM_REF_SUP8: begin
            p.status = ST_UNSUPPORTED;
         end
         default: begin
            p.status = ST_RESERVED;
         end
      endcase
      return p;
   endfunction

   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign item_take = req_valid && !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign remain_dec    = remain_ff - {{(REMAIN_W-1){1'b0}}, 1'b1};
   assign lenfix_acc    = length_acc_ff |
                          ({{(REMAIN_W-BYTE_W){1'b0}}, req_word.data_byte} << shift_ff[4:0]);
   assign leb_acc       = shift_ff[6] ? length_acc_ff :
                          (length_acc_ff |
                           ({{(REMAIN_W-BYTE_W+1){1'b0}}, req_word.data_byte[6:0]}
                            << shift_ff[5:0]));
   assign leb_shift_sum = shift_ff + 7'd7;
   assign leb_shift     = (leb_shift_sum > LEB_SHIFT_MAX) ? LEB_SHIFT_MAX : leb_shift_sum;
   assign len_left_dec  = len_left_ff - 3'd1;
   assign consumed_inc  = (consumed_ff == '1) ? consumed_ff : consumed_ff + 32'd1;
   assign plan          = plan_form(begin_form, offset_size_ff, address_size_ff);

   always_comb begin
      phase_in      = phase_ff;
      remain_in     = remain_ff;
      length_acc_in = length_acc_ff;
      shift_in      = shift_ff;
      len_left_in   = len_left_ff;
      consumed_in   = consumed_ff;
      form_in       = form_ff;
      status_c      = ST_MORE;
      do_begin      = 1'b0;
      begin_form    = req_word.form_code;
      begin_big     = 1'b0;

      if (req_word.opcode == OP_FORM) begin
         if (phase_ff != PH_IDLE) begin
            status_c = ST_UNEXPECTED;
         end else begin
            consumed_in = '0;
            do_begin    = 1'b1;
         end
      end else if (phase_ff == PH_IDLE) begin
         status_c = ST_UNEXPECTED;
      end else begin
         consumed_in = consumed_inc;
         case (phase_ff)
            PH_FIXED, PH_BLOCK: begin
               remain_in = remain_dec;
               if (remain_dec == '0) begin
                  phase_in = PH_IDLE;
                  status_c = ST_DONE;
               end
            end
            PH_LENFIX: begin
               length_acc_in = lenfix_acc;
               shift_in      = shift_ff + 7'd8;
               len_left_in   = len_left_dec;
               if (len_left_dec == '0) begin
                  if (lenfix_acc == '0) begin
                     phase_in = PH_IDLE;
                     status_c = ST_DONE;
                  end else begin
                     remain_in = lenfix_acc;
                     phase_in  = PH_BLOCK;
                  end
               end
            end
            PH_LENLEB: begin
               length_acc_in = leb_acc;
               shift_in      = leb_shift;
               if (!req_word.data_byte[7]) begin
                  if (leb_acc == '0) begin
                     phase_in = PH_IDLE;
                     status_c = ST_DONE;
                  end else begin
                     remain_in = leb_acc;
                     phase_in  = PH_BLOCK;
                  end
               end
            end
            PH_STRING: begin
               if (req_word.data_byte == '0) begin
                  phase_in = PH_IDLE;
                  status_c = ST_DONE;
               end
            end
            PH_LEB: begin
               if (!req_word.data_byte[7]) begin
                  phase_in = PH_IDLE;
                  status_c = ST_DONE;
               end
            end
            PH_INDIRECT: begin
               length_acc_in = leb_acc;
               shift_in      = leb_shift;
               if (!req_word.data_byte[7]) begin
                  do_begin   = 1'b1;
                  begin_form = leb_acc[BYTE_W-1:0];
                  begin_big  = |leb_acc[REMAIN_W-1:BYTE_W];
               end
            end
            default: begin
               phase_in = PH_IDLE;
               status_c = ST_UNEXPECTED;
            end
         endcase
      end

      if (do_begin) begin
         form_in       = begin_form;
         length_acc_in = '0;
         shift_in      = '0;
         len_left_in   = '0;
         remain_in     = '0;
         phase_in      = PH_IDLE;
         if (begin_big) begin
            status_c = ST_RESERVED;
         end else begin
            status_c = plan.status;
            phase_in = plan.phase;
            if (plan.phase == PH_FIXED) begin
               if (plan.count == '0) begin
                  phase_in = PH_IDLE;
                  status_c = ST_DONE;
               end else begin
                  remain_in = {{(REMAIN_W-PLANCNT_W){1'b0}}, plan.count};
               end
            end else if (plan.phase == PH_LENFIX) begin
               len_left_in = plan.count[LENLEFT_W-1:0];
            end
         end
      end

      result_c.status         = status_c;
      result_c.bytes_consumed = consumed_in;
      result_c.resolved_form  = form_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_size_ff  <= OFFSET_SIZE_RESET;
         address_size_ff <= ADDRESS_SIZE_RESET;
      end else if (csr_wen) begin
         if (csr_index == CSR_OFFSET_SIZE) begin
            offset_size_ff <= csr_wdata;
         end else if (csr_index == CSR_ADDRESS_SIZE) begin
            address_size_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         remain_ff     <= '0;
         length_acc_ff <= '0;
         shift_ff      <= '0;
         len_left_ff   <= '0;
         consumed_ff   <= '0;
         form_ff       <= '0;
      end else if (item_take) begin
         phase_ff      <= phase_in;
         remain_ff     <= remain_in;
         length_acc_ff <= length_acc_in;
         shift_ff      <= shift_in;
         len_left_ff   <= len_left_in;
         consumed_ff   <= consumed_in;
         form_ff       <= form_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= item_take;
         end
      end else if (item_take) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            rsp_word_ff <= skid_word_ff;
         end else if (item_take) begin
            rsp_word_ff <= result_c;
         end
      end else if (item_take) begin
         skid_word_ff <= result_c;
      end
   end

   `ASSERT_IMPLIES(a_skid_behind_output, clock, reset, skid_valid_ff, rsp_valid_ff)
   `ASSERT_NEXT(a_stalled_word_to_skid, clock, reset,
                rsp_valid_ff && rsp_stall && item_take, skid_valid_ff)
   `ASSERT_IMPLIES(a_len_left_only_in_lenfix, clock, reset,
                   len_left_ff != '0, phase_ff == PH_LENFIX)
   `ASSERT_IMPLIES(a_counting_has_bytes, clock, reset,
                   phase_ff == PH_FIXED || phase_ff == PH_BLOCK, remain_ff != '0)
   `ASSERT_IMPLIES(a_status_in_range, clock, reset,
                   rsp_valid_ff, rsp_word_ff.status <= ST_UNEXPECTED)

endmodule
